// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of the request queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CRQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CRQ_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/crq_pkg.sv
// Types and constants of the clock-ordered request queue.
package crq_pkg;

	localparam int CRQ_DEPTH       = 16;
	localparam int CRQ_SOURCE_BITS = 8;
	localparam int CRQ_CLOCK_BITS  = 32;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_QUERY  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_RMS,
		ST_RMSH,
		ST_QRY,
		ST_DONE
	} state_t;

endpackage

// File: hw/rtl/crq_mem.sv
// Entry memory of the request queue: one write port, one registered read port.
module crq_mem #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/clock_ordered_request_queue_core.sv
// Top level of the clock-ordered request queue: sequencer around the entry memory.
//
//   channel   handshake        payload
//   command   start / busy     mode, source, clock_req
//   result    done (strobe)    head_source, head_valid, entry_count,
//                              source_position, insert_dropped
//
// Every entry visit goes through the single read port of the entry memory.
// A query reads every queued request once; an insert first walks from the tail towards the head,
// a remove first scans all entries and then shifts those behind the hit, and both end with a query.
// After reset the queue is empty and a command may be given at once.
// busy is high from the accepting edge up to and including the cycle of done.
// The result is shown for one cycle only; the receiver cannot stall it.
module clock_ordered_request_queue_core import crq_pkg::*; #(
	parameter int DEPTH       = CRQ_DEPTH,
	parameter int SOURCE_BITS = CRQ_SOURCE_BITS,
	parameter int CLOCK_BITS  = CRQ_CLOCK_BITS,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             mode,
	input  logic [SOURCE_BITS-1:0] source,
	input  logic [CLOCK_BITS-1:0]  clock_req,
	output logic                   done,
	output logic [SOURCE_BITS-1:0] head_source,
	output logic                   head_valid,
	output logic [CW-1:0]          entry_count,
	output logic [CW-1:0]          source_position,
	output logic                   insert_dropped
);

	localparam int WW = SOURCE_BITS + CLOCK_BITS;

	state_t state_q, state_d;

	logic [SOURCE_BITS-1:0] src_q;
	logic [CLOCK_BITS-1:0]  clk_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          idx_q;
	logic                   vld_s1;
	logic [CW-1:0]          idx_s1;
	logic                   found_q;
	logic [CW-1:0]          hit_q;
	logic [CLOCK_BITS-1:0]  best_q;
	logic                   pfound_q;
	logic [CW-1:0]          pos_q;
	logic [SOURCE_BITS-1:0] head_q;
	logic                   drop_q;

	logic                   rd_en;
	logic [CW-1:0]          raddr_full;
	logic                   we;
	logic [CW-1:0]          waddr_full;
	logic [WW-1:0]          wdata;
	logic [WW-1:0]          rdata;
	logic [WW-1:0]          new_word;
	logic [SOURCE_BITS-1:0] r_src;
	logic [CLOCK_BITS-1:0]  r_clk;
	logic                   ent_less;
	logic                   ins_fin;
	logic                   rm_take;
	logic                   rm_fin;

	assign new_word   = {clk_q, src_q};
	assign r_src      = rdata[SOURCE_BITS-1:0];
	assign r_clk      = rdata[WW-1:SOURCE_BITS];
	assign ent_less   = rdata < new_word;
	assign raddr_full = (state_q == ST_INS) ? idx_q - CW'(1) : idx_q;

	crq_mem #(
		.WIDTH(WW),
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr_full[AW-1:0]),
		.wdata(wdata),
		.raddr(raddr_full[AW-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		we         = 1'b0;
		waddr_full = '0;
		wdata      = rdata;
		ins_fin    = 1'b0;
		rm_take    = 1'b0;
		rm_fin     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (mode_t'(mode))
						MODE_INSERT: begin
							state_d = (cnt_q == CW'(DEPTH)) ? ST_QRY : ST_INS;
						end
						MODE_REMOVE: state_d = ST_RMS;
						MODE_QUERY:  state_d = ST_QRY;
						default:     state_d = ST_QRY;
					endcase
				end
			end
			ST_INS: begin
				rd_en = (idx_q != '0);
				if (vld_s1) begin
					we         = 1'b1;
					waddr_full = idx_s1 + CW'(1);
					if (ent_less) begin
						wdata   = new_word;
						rd_en   = 1'b0;
						ins_fin = 1'b1;
						state_d = ST_QRY;
					end
				end else if (idx_q == '0) begin
					we      = 1'b1;
					wdata   = new_word;
					ins_fin = 1'b1;
					state_d = ST_QRY;
				end
			end
			ST_RMS: begin
				rd_en = (idx_q != cnt_q);
				if (vld_s1 && r_src == src_q && (!found_q || r_clk < best_q)) begin
					rm_take = 1'b1;
				end
				if (!vld_s1 && idx_q == cnt_q) begin
					state_d = found_q ? ST_RMSH : ST_QRY;
				end
			end
			ST_RMSH: begin
				rd_en = (idx_q != cnt_q);
				if (vld_s1) begin
					we         = 1'b1;
					waddr_full = idx_s1 - CW'(1);
				end
				if (!vld_s1 && idx_q == cnt_q) begin
					rm_fin  = 1'b1;
					state_d = ST_QRY;
				end
			end
			ST_QRY: begin
				rd_en = (idx_q != cnt_q);
				if (!vld_s1 && idx_q == cnt_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
			pfound_q <= 1'b0;
			drop_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			if (state_d != state_q) begin
				case (state_d)
					ST_INS:  idx_q <= cnt_q;
					ST_RMSH: idx_q <= hit_q + CW'(1);
					default: idx_q <= '0;
				endcase
			end else if (rd_en) begin
				idx_q <= (state_q == ST_INS) ? idx_q - CW'(1) : idx_q + CW'(1);
			end
			if (ins_fin) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rm_fin) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (state_q == ST_IDLE && start) begin
				found_q  <= 1'b0;
				pfound_q <= 1'b0;
				drop_q   <= (mode_t'(mode) == MODE_INSERT) && (cnt_q == CW'(DEPTH));
			end
			if (rm_take) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_QRY && vld_s1 && r_src == src_q) begin
				pfound_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= raddr_full;
		if (state_q == ST_IDLE && start) begin
			src_q <= source;
			clk_q <= clock_req;
		end
		if (rm_take) begin
			hit_q  <= idx_s1;
			best_q <= r_clk;
		end
		if (state_q == ST_QRY && vld_s1) begin
			if (idx_s1 == '0) begin
				head_q <= r_src;
			end
			if (r_src == src_q && !pfound_q) begin
				pos_q <= idx_s1;
			end
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = (state_q == ST_DONE);
	assign head_valid      = (cnt_q != '0);
	assign head_source     = head_valid ? head_q : '0;
	assign entry_count     = cnt_q;
	assign source_position = pfound_q ? pos_q : cnt_q;
	assign insert_dropped  = drop_q;

endmodule

// File: hw/rtl/crq_checker.sv
// Port-level assertions of the request queue and their binding to the top level.
`include "assert_macros.svh"

module crq_checker #(
	parameter int DEPTH       = 16,
	parameter int SOURCE_BITS = 8,
	parameter int CW          = 5
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input logic [SOURCE_BITS-1:0] head_source,
	input logic                   head_valid,
	input logic [CW-1:0]          entry_count,
	input logic [CW-1:0]          source_position,
	input logic                   insert_dropped
);

	`CRQ_ASSERT_NXT(a_accept_busy, start && !busy, busy, "Accepted item did not raise busy.")
	`CRQ_ASSERT_IMP(a_done_busy, done, busy, "Result shown while idle.")
	`CRQ_ASSERT_IMP(a_head_valid, done, head_valid == (entry_count != '0), "Head flag disagrees with count.")
	`CRQ_ASSERT_IMP(a_position, done, source_position <= entry_count, "Position beyond the count.")
	`CRQ_ASSERT_IMP(a_dropped_full, done && insert_dropped, entry_count == CW'(DEPTH), "Item dropped on a queue that was not full.")

endmodule

bind clock_ordered_request_queue_core crq_checker #(
	.DEPTH      (DEPTH),
	.SOURCE_BITS(SOURCE_BITS),
	.CW         (CW)
) u_crq_checker (.*);
